// ===== sv/uia_pkg.sv =====
// Shared types and constants for the 128-bit integer ALU.
`timescale 1ns / 1ps
`default_nettype none
package uia_pkg;

  localparam int unsigned WordW  = 64;
  localparam int unsigned OperW  = 128;
  localparam int unsigned ProdW  = 256;
  localparam int unsigned LimbW  = 32;
  localparam int unsigned Limbs  = OperW / LimbW;
  localparam int unsigned ShiftW = 8;
  localparam int unsigned FloorW = 7;
  localparam int unsigned CeilW  = 8;

  typedef enum logic [3:0] {
    OP_AND     = 4'd0,
    OP_OR      = 4'd1,
    OP_XOR     = 4'd2,
    OP_NOT     = 4'd3,
    OP_SHL     = 4'd4,
    OP_SHR     = 4'd5,
    OP_EQ      = 4'd6,
    OP_GT      = 4'd7,
    OP_GE      = 4'd8,
    OP_LT      = 4'd9,
    OP_LE      = 4'd10,
    OP_ADD     = 4'd11,
    OP_SUB     = 4'd12,
    OP_MULLO   = 4'd13,
    OP_MULFULL = 4'd14,
    OP_LOG2    = 4'd15
  } op_e;

  // everything but the products, settled in the first stage
  typedef struct packed {
    logic [OperW-1:0]  word;
    logic              carry;
    logic              flag;
    logic [FloorW-1:0] lfloor;
    logic [CeilW-1:0]  lceil;
    logic              zero;
  } misc_t;

endpackage
`default_nettype wire

// ===== sv/uia_misc.sv =====
// Bitwise, shift, compare, add/sub and log2 results (combinational).
`timescale 1ns / 1ps
`default_nettype none
module uia_misc (
  input  var uia_pkg::op_e                  op_i,
  input  wire logic [uia_pkg::OperW-1:0]    a_i,
  input  wire logic [uia_pkg::OperW-1:0]    b_i,
  input  wire logic [uia_pkg::ShiftW-1:0]   sh_i,
  output uia_pkg::misc_t                    res_o
);

  logic [uia_pkg::OperW:0]       sum;
  logic [uia_pkg::OperW-1:0]     diff;
  logic [uia_pkg::OperW-1:0]     am1;
  logic                          gt, eq, pow2, big;
  logic [uia_pkg::FloorW-1:0]    top;

  always_comb begin
    top = '0;
    for (int i = 0; i < uia_pkg::OperW; i++) begin
      if (a_i[i]) top = uia_pkg::FloorW'(i);
    end
  end

  assign sum  = {1'b0, a_i} + {1'b0, b_i};
  assign diff = a_i - b_i;
  assign am1  = a_i - uia_pkg::OperW'(1);
  assign gt   = a_i > b_i;
  assign eq   = a_i == b_i;
  assign pow2 = (a_i & am1) == '0;
  assign big  = sh_i[uia_pkg::ShiftW-1];

  always_comb begin
    res_o = '0;
    case (op_i)
      uia_pkg::OP_AND: res_o.word = a_i & b_i;
      uia_pkg::OP_OR:  res_o.word = a_i | b_i;
      uia_pkg::OP_XOR: res_o.word = a_i ^ b_i;
      uia_pkg::OP_NOT: res_o.word = ~a_i;
      uia_pkg::OP_SHL: res_o.word = big ? '0 : a_i << sh_i[uia_pkg::ShiftW-2:0];
      uia_pkg::OP_SHR: res_o.word = big ? '0 : a_i >> sh_i[uia_pkg::ShiftW-2:0];
      uia_pkg::OP_EQ:  res_o.flag = eq;
      uia_pkg::OP_GT:  res_o.flag = gt;
      uia_pkg::OP_GE:  res_o.flag = gt | eq;
      uia_pkg::OP_LT:  res_o.flag = ~gt & ~eq;
      uia_pkg::OP_LE:  res_o.flag = ~gt;
      uia_pkg::OP_ADD: begin
        res_o.word  = sum[uia_pkg::OperW-1:0];
        res_o.carry = sum[uia_pkg::OperW];
      end
      uia_pkg::OP_SUB: res_o.word = diff;
      uia_pkg::OP_LOG2: begin
        if (a_i == '0) begin
          res_o.zero = 1'b1;
        end else begin
          res_o.lfloor = top;
          res_o.lceil  = {1'b0, top} + uia_pkg::CeilW'(!pow2);
        end
      end
      default: res_o = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/uia_mul.sv =====
// Three-stage 128x128 multiplier built from 32x32 partial products.
`timescale 1ns / 1ps
`default_nettype none
module uia_mul (
  input  wire logic                        clk_i,
  input  wire logic                        en_i,
  input  wire logic [uia_pkg::OperW-1:0]   a_i,
  input  wire logic [uia_pkg::OperW-1:0]   b_i,
  output logic      [uia_pkg::ProdW-1:0]   prod_o
);

  localparam int unsigned LW = uia_pkg::LimbW;
  localparam int unsigned HW = uia_pkg::OperW;

  logic [2*LW-1:0] pp_q [uia_pkg::Limbs][uia_pkg::Limbs];
  logic [HW-1:0]   hp_d [2][2];
  logic [HW-1:0]   hp_q [2][2];
  logic [uia_pkg::ProdW-1:0] prod_d, prod_q;

  // stage 1: sixteen 32x32 products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < uia_pkg::Limbs; i++) begin
        for (int j = 0; j < uia_pkg::Limbs; j++) begin
          pp_q[i][j] <= a_i[i*LW +: LW] * b_i[j*LW +: LW];
        end
      end
    end
  end

  // stage 2: four 64x64 products
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 2; j++) begin
        hp_d[i][j] = HW'(pp_q[2*i][2*j])
                   + (HW'(pp_q[2*i][2*j+1]) << LW)
                   + (HW'(pp_q[2*i+1][2*j]) << LW)
                   + (HW'(pp_q[2*i+1][2*j+1]) << (2*LW));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) hp_q <= hp_d;
  end

  // stage 3: full product
  assign prod_d = uia_pkg::ProdW'(hp_q[0][0])
                + (uia_pkg::ProdW'(hp_q[0][1]) << uia_pkg::WordW)
                + (uia_pkg::ProdW'(hp_q[1][0]) << uia_pkg::WordW)
                + (uia_pkg::ProdW'(hp_q[1][1]) << HW);

  always_ff @(posedge clk_i) begin
    if (en_i) prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule
`default_nettype wire

// ===== sv/uint128_integer_alu.sv =====
// Top level of the pipelined 128-bit integer ALU.
`timescale 1ns / 1ps
`default_nettype none
// Four register stages: partial products, 64x64 sums, 128x128 sum, output
// register; the multiplier's partial-product tree sets the depth. One item
// may enter each cycle while no finished result is stalled; the whole
// pipeline freezes only while a finished result is stalled.
module uint128_integer_alu (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [3:0]                   operation_i,
  input  wire logic [uia_pkg::WordW-1:0]    a_low_i,
  input  wire logic [uia_pkg::WordW-1:0]    a_high_i,
  input  wire logic [uia_pkg::WordW-1:0]    b_low_i,
  input  wire logic [uia_pkg::WordW-1:0]    b_high_i,
  input  wire logic [uia_pkg::ShiftW-1:0]   shift_amount_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [uia_pkg::WordW-1:0]         word_zero_o,
  output logic [uia_pkg::WordW-1:0]         word_one_o,
  output logic [uia_pkg::WordW-1:0]         word_two_o,
  output logic [uia_pkg::WordW-1:0]         word_three_o,
  output logic                              compare_flag_o,
  output logic [uia_pkg::FloorW-1:0]        log2_floor_o,
  output logic [uia_pkg::CeilW-1:0]         log2_ceiling_o,
  output logic                              zero_operand_o
);

  localparam int unsigned W = uia_pkg::WordW;

  logic en;
  logic [uia_pkg::OperW-1:0] a, b;
  logic [uia_pkg::ProdW-1:0] prod;
  uia_pkg::op_e   op_in;
  uia_pkg::misc_t misc_d;
  uia_pkg::misc_t m1_q, m2_q, m3_q;
  uia_pkg::op_e   op1_q, op2_q, op3_q;
  logic v1_q, v2_q, v3_q, vo_q;
  logic [4*W-1:0] wo_d, wo_q;
  logic flag_q, zero_q;
  logic [uia_pkg::FloorW-1:0] fl_q;
  logic [uia_pkg::CeilW-1:0]  cl_q;

  assign en         = !(vo_q && out_stall_i);
  assign in_stall_o = !en;
  assign a     = {a_high_i, a_low_i};
  assign b     = {b_high_i, b_low_i};
  assign op_in = uia_pkg::op_e'(operation_i);

  uia_misc u_misc (
    .op_i  (op_in),
    .a_i   (a),
    .b_i   (b),
    .sh_i  (shift_amount_i),
    .res_o (misc_d)
  );

  uia_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (en),
    .a_i    (a),
    .b_i    (b),
    .prod_o (prod)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      vo_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_q  <= misc_d;
      op1_q <= op_in;
      m2_q  <= m1_q;
      op2_q <= op1_q;
      m3_q  <= m2_q;
      op3_q <= op2_q;
    end
  end

  always_comb begin
    case (op3_q)
      uia_pkg::OP_MULLO:   wo_d = {{(2*W){1'b0}}, prod[2*W-1:0]};
      uia_pkg::OP_MULFULL: wo_d = prod;
      default: wo_d = {{(W){1'b0}}, {(W-1){1'b0}}, m3_q.carry, m3_q.word};
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      wo_q   <= wo_d;
      flag_q <= m3_q.flag;
      fl_q   <= m3_q.lfloor;
      cl_q   <= m3_q.lceil;
      zero_q <= m3_q.zero;
    end
  end

  assign out_valid_o    = vo_q;
  assign word_zero_o    = wo_q[W-1:0];
  assign word_one_o     = wo_q[2*W-1:W];
  assign word_two_o     = wo_q[3*W-1:2*W];
  assign word_three_o   = wo_q[4*W-1:3*W];
  assign compare_flag_o = flag_q;
  assign log2_floor_o   = fl_q;
  assign log2_ceiling_o = cl_q;
  assign zero_operand_o = zero_q;

endmodule
`default_nettype wire

// ===== sv/uia_checker.sv =====
// Port-level assertions for the 128-bit integer ALU and their bind.
`timescale 1ns / 1ps
`default_nettype none
module uia_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        out_valid_o,
  input wire logic                        out_stall_i,
  input wire logic [uia_pkg::WordW-1:0]   word_zero_o,
  input wire logic [uia_pkg::WordW-1:0]   word_three_o,
  input wire logic                        compare_flag_o,
  input wire logic [uia_pkg::FloorW-1:0]  log2_floor_o,
  input wire logic [uia_pkg::CeilW-1:0]   log2_ceiling_o,
  input wire logic                        zero_operand_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(word_zero_o))
    else $error("stalled result changed");

  a_flag_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && compare_flag_o |-> word_zero_o == '0 && word_three_o == '0)
    else $error("compare result carries data words");

  a_log_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_operand_o |-> log2_floor_o == '0 && log2_ceiling_o == '0)
    else $error("log2 of zero not zero");

  a_ceil: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> log2_ceiling_o == {1'b0, log2_floor_o}
                 || log2_ceiling_o == {1'b0, log2_floor_o} + 8'd1)
    else $error("log2 ceiling off floor");

endmodule

bind uint128_integer_alu uia_checker u_uia_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .word_zero_o    (word_zero_o),
  .word_three_o   (word_three_o),
  .compare_flag_o (compare_flag_o),
  .log2_floor_o   (log2_floor_o),
  .log2_ceiling_o (log2_ceiling_o),
  .zero_operand_o (zero_operand_o)
);
`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for the pipelined 128-bit integer ALU.
`timescale 1ns / 1ps
module tb;

  typedef struct packed {
    logic [63:0] w0, w1, w2, w3;
    logic        flag;
    logic [6:0]  lfloor;
    logic [7:0]  lceil;
    logic        zero;
  } alu_res_t;

  class alu_scoreboard;
    alu_res_t pending[$];
    int       mismatches;

    function alu_res_t compute(uia_pkg::op_e op, logic [127:0] a, logic [127:0] b,
                               logic [7:0] sh);
      alu_res_t     r;
      logic [255:0] p;
      logic [128:0] s;
      int           fl;
      r = '0;
      case (op)
        uia_pkg::OP_AND: {r.w1, r.w0} = a & b;
        uia_pkg::OP_OR:  {r.w1, r.w0} = a | b;
        uia_pkg::OP_XOR: {r.w1, r.w0} = a ^ b;
        uia_pkg::OP_NOT: {r.w1, r.w0} = ~a;
        uia_pkg::OP_SHL: if (sh < 128) {r.w1, r.w0} = a << sh;
        uia_pkg::OP_SHR: if (sh < 128) {r.w1, r.w0} = a >> sh;
        uia_pkg::OP_EQ:  r.flag = (a == b);
        uia_pkg::OP_GT:  r.flag = (a > b);
        uia_pkg::OP_GE:  r.flag = (a >= b);
        uia_pkg::OP_LT:  r.flag = (a < b);
        uia_pkg::OP_LE:  r.flag = (a <= b);
        uia_pkg::OP_ADD: begin
          s = {1'b0, a} + {1'b0, b};
          {r.w1, r.w0} = s[127:0];
          r.w2 = {63'd0, s[128]};
        end
        uia_pkg::OP_SUB: {r.w1, r.w0} = a - b;
        uia_pkg::OP_MULLO, uia_pkg::OP_MULFULL: begin
          p = {128'd0, a} * {128'd0, b};
          if (op == uia_pkg::OP_MULLO) {r.w1, r.w0} = p[127:0];
          else {r.w3, r.w2, r.w1, r.w0} = p;
        end
        default: begin
          if (a == 0) r.zero = 1'b1;
          else begin
            fl = 0;
            for (int i = 0; i < 128; i++) if (a[i]) fl = i;
            r.lfloor = fl[6:0];
            r.lceil = ((a & (a - 1)) == 0) ? fl[7:0] : fl[7:0] + 8'd1;
          end
        end
      endcase
      return r;
    endfunction

    function void note_input(uia_pkg::op_e op, logic [127:0] a, logic [127:0] b,
                             logic [7:0] sh);
      pending.push_back(compute(op, a, b, sh));
    endfunction

    function void check_result(alu_res_t got);
      alu_res_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %h", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch w0 %h/%h w1 %h/%h w2 %h/%h w3 %h/%h", want.w0, got.w0,
                   want.w1, got.w1, want.w2, got.w2, want.w3, got.w3);
          $display("  flag %b/%b floor %0d/%0d ceil %0d/%0d zero %b/%b", want.flag,
                   got.flag, want.lfloor, got.lfloor, want.lceil, got.lceil,
                   want.zero, got.zero);
        end
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [3:0]  operation_i = '0;
  logic [63:0] a_low_i = '0, a_high_i = '0, b_low_i = '0, b_high_i = '0;
  logic [7:0]  shift_amount_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b1;
  logic [63:0] word_zero_o, word_one_o, word_two_o, word_three_o;
  logic        compare_flag_o, zero_operand_o;
  logic [6:0]  log2_floor_o;
  logic [7:0]  log2_ceiling_o;

  alu_scoreboard sb = new();
  bit            hold_off = 1'b0;
  int            idle_cycles = 0;

  always #1 clk_i = ~clk_i;

  uint128_integer_alu i_dut (.*);

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return 64'd1 << $urandom_range(0, 63);
      3: return {32'd0, $urandom()};
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // valid stays high after an item so back-to-back items need no gap edge
  task automatic send_item(uia_pkg::op_e op, logic [127:0] a, logic [127:0] b,
                           logic [7:0] sh, int gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    {a_high_i, a_low_i} <= a;
    {b_high_i, b_low_i} <= b;
    shift_amount_i <= sh;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(op, a, b, sh);
  endtask

  task automatic send_random(int gap);
    logic [127:0] a, b;
    a = {rand_word(), rand_word()};
    b = ($urandom_range(0, 7) == 0) ? a : {rand_word(), rand_word()};
    send_item(uia_pkg::op_e'($urandom_range(0, 15)), a, b, 8'($urandom()), gap);
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    int wait_n;
    @(posedge rst_ni);
    forever begin
      wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      if (wait_n > 0 || hold_off) begin
        out_stall_i <= 1'b1;
        repeat (wait_n) @(posedge clk_i);
        while (hold_off) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_result({word_zero_o, word_one_o, word_two_o, word_three_o,
                       compare_flag_o, log2_floor_o, log2_ceiling_o, zero_operand_o});
    end
  end

  // Watchdog on cycles with no accepted item on either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("uint128_integer_alu regression: fail");
      $finish;
    end
  end

  initial begin
    logic [127:0] ones;
    ones = '1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed corners
    for (int op = 0; op < 16; op++)
      send_item(uia_pkg::op_e'(op), ones, 128'd1, 8'd0, 0);
    send_item(uia_pkg::OP_SHL, ones, 0, 8'd64, 0);
    send_item(uia_pkg::OP_SHL, ones, 0, 8'd127, 1);
    send_item(uia_pkg::OP_SHR, ones, 0, 8'd128, 0);
    send_item(uia_pkg::OP_SHR, ones, 0, 8'd255, 0);
    send_item(uia_pkg::OP_LOG2, 0, 0, 0, 0);
    send_item(uia_pkg::OP_LOG2, 128'd1 << 100, 0, 0, 0);
    send_item(uia_pkg::OP_SUB, 0, 128'd1, 0, 0);
    send_item(uia_pkg::OP_MULFULL, ones, ones, 0, 2);
    send_item(uia_pkg::OP_LT, ones, ones, 0, 0);
    // receiver holds off while the sender keeps offering
    fork
      begin hold_off = 1'b1; repeat (60) @(posedge clk_i); hold_off = 1'b0; end
      repeat (20) send_random(0);
    join
    in_valid_i <= 1'b0;
    // drain fully before going on
    wait (sb.pending.size() == 0);
    for (int n = 0; n < 620; n++)
      send_random(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10));
    in_valid_i <= 1'b0;
    wait (sb.pending.size() == 0);
    repeat (10) @(posedge clk_i);
    if (sb.mismatches == 0) $display("uint128_integer_alu regression: pass");
    else $display("uint128_integer_alu regression: fail");
    $finish;
  end
endmodule

// ===== sim.f =====
sv/uia_pkg.sv
sv/uia_misc.sv
sv/uia_mul.sv
sv/uint128_integer_alu.sv
sv/uia_checker.sv
bench/tb.sv
